@@ sv/dss_pkg.sv @@
// shared types, widths and constant tables for the dimmable seven-segment scan
// no dependencies
package dss_pkg;

  localparam int unsigned VALUE_W     = 14;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DEB_W       = 16;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned SEG_W       = 7;
  localparam int unsigned IDX_OUT_W   = 2;
  localparam int unsigned STEP_W      = 2;
  localparam int unsigned DIGITS_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(50);

  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = LEVEL_W'(64);
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = LEVEL_W'(128);
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = LEVEL_W'(255);

  localparam logic [STEP_W-1:0] STEP_LOW  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_MID  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_HIGH = 2'd2;

  // one refresh pass as handed from front to back
  typedef struct packed {
    logic               disp;
    logic               point;
    logic [LEVEL_W-1:0] level;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] quot;   // estimate of value / 10^digits
  } dss_entry_t;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of(input logic [STEP_W-1:0] step);
    logic [LEVEL_W-1:0] lvl;
    case (step)
      STEP_LOW:  lvl = LEVEL_LOW;
      STEP_MID:  lvl = LEVEL_MID;
      STEP_HIGH: lvl = LEVEL_HIGH;
      default:   lvl = LEVEL_LOW;
    endcase
    return lvl;
  endfunction

  // a..g in bits 0..6
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ sv/dss_front.sv @@
// front end: button debounce, brightness stepping and first reduction of the value
// depends on dss_pkg
module dss_front import dss_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DEB_W-1:0]   cfg_wdata_i,
  input  logic               accept_i,
  input  logic               button_low_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               show_point_i,
  input  logic               display_id_i,
  output dss_entry_t         entry_o
);

  localparam longint MOD    = pow10(int'(DIGITS));
  localparam bit     REDUCE = (MOD < longint'(64'd1 << VALUE_W));

  logic [DEB_W-1:0]  debounce_q;
  logic              held_q, held_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TIME_W-1:0] elapsed;
  logic              take;
  logic [VALUE_W-1:0] quot;

  assign elapsed = now_ms_i - last_q;
  assign take    = button_low_i && !held_q && (elapsed > TIME_W'(debounce_q));

  always_comb begin
    held_d = held_q;
    last_d = last_q;
    step_d = step_q;
    if (button_low_i) begin
      if (take) begin
        held_d = 1'b1;
        last_d = now_ms_i;
        step_d = (step_q < STEP_HIGH) ? step_q + 2'd1 : STEP_LOW;
      end
    end else begin
      held_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      held_q     <= 1'b0;
      last_q     <= '0;
      step_q     <= STEP_LOW;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        held_q <= held_d;
        last_q <= last_d;
        step_q <= step_d;
      end
    end
  end

  // quotient by reciprocal, may come out one low; the back end corrects it
  if (REDUCE) begin : g_reduce
    localparam int     L   = $clog2(MOD);
    localparam int     S   = int'(VALUE_W) + L;
    localparam longint M   = (longint'(64'd1) << S) / MOD;
    localparam int     P_W = 2 * int'(VALUE_W) + 1;
    logic [P_W-1:0] prod;
    assign prod = P_W'(value_i) * P_W'(M);
    assign quot = VALUE_W'(prod >> S);
  end else begin : g_no_reduce
    assign quot = '0;
  end

  assign entry_o.disp  = display_id_i;
  assign entry_o.point = show_point_i;
  assign entry_o.level = level_of(step_d);
  assign entry_o.value = value_i;
  assign entry_o.quot  = quot;

endmodule

@@ sv/dss_queue.sv @@
// two-entry queue between front and back ends
// depends on dss_pkg
module dss_queue import dss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dss_entry_t push_data_i,
  input  logic       pop_i,
  output dss_entry_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dss_entry_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/dss_back.sv @@
// back end: digit sequencer, one digit word per cycle while the output is not stalled, with output register
// depends on dss_pkg
module dss_back import dss_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dss_entry_t           head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 target_display_o,
  output logic [IDX_OUT_W-1:0] digit_index_o,
  output logic [SEG_W-1:0]     segments_o,
  output logic [LEVEL_W-1:0]   segment_level_o,
  output logic [LEVEL_W-1:0]   point_level_o,
  output logic                 last_o
);

  localparam longint MOD    = pow10(int'(DIGITS));
  localparam bit     REDUCE = (MOD < longint'(64'd1 << VALUE_W));
  localparam int     MOD_W  = $clog2(MOD);
  localparam int     CMP_W  = (MOD_W > int'(VALUE_W)) ? MOD_W : int'(VALUE_W);
  localparam int     IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // multiples k * 10^(digits-1-pos) for every position
  logic [CMP_W-1:0] tab [DIGITS][10];
  for (genvar g = 0; g < int'(DIGITS); g++) begin : g_pos
    for (genvar k = 0; k < 10; k++) begin : g_mult
      assign tab[g][k] = CMP_W'(longint'(k) * pow10(int'(DIGITS) - 1 - g));
    end
  end

  logic               active_q;
  logic [IDX_W-1:0]   idx_q;
  logic [VALUE_W-1:0] rem_q;
  logic               disp_q, point_q;
  logic [LEVEL_W-1:0] level_q;
  logic               out_valid_q;

  logic               adv, at_last, load;
  logic [CMP_W-1:0]   rem_ext;
  logic [3:0]         digit;
  logic [CMP_W-1:0]   sub;
  logic [VALUE_W-1:0] rem0;

  assign at_last = (idx_q == IDX_W'(DIGITS - 1));
  assign adv     = active_q && (!out_valid_q || !out_stall_i);
  assign load    = !empty_i && (!active_q || (adv && at_last));
  assign pop_o   = load;

  // fold value down below 10^digits
  if (REDUCE) begin : g_reduce
    localparam int QM_W = int'(VALUE_W) + MOD_W;
    logic [QM_W-1:0]    qm;
    logic [VALUE_W-1:0] diff;
    assign qm   = QM_W'(head_i.quot) * QM_W'(MOD);
    assign diff = head_i.value - VALUE_W'(qm);
    assign rem0 = (diff >= VALUE_W'(MOD)) ? diff - VALUE_W'(MOD) : diff;
  end else begin : g_no_reduce
    assign rem0 = head_i.value;
  end

  assign rem_ext = CMP_W'(rem_q);

  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      digit = digit + 4'(rem_ext >= tab[idx_q][k]);
    end
    sub = tab[idx_q][digit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (adv && at_last) begin
        active_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem0;
      disp_q  <= head_i.disp;
      point_q <= head_i.point;
      level_q <= head_i.level;
    end else if (adv) begin
      rem_q <= VALUE_W'(rem_ext - sub);
    end
    if (adv) begin
      target_display_o <= disp_q;
      digit_index_o    <= IDX_OUT_W'(idx_q);
      segments_o       <= seg_of(digit);
      segment_level_o  <= level_q;
      point_level_o    <= (point_q && (32'(idx_q) == 32'd2)) ? level_q : '0;
      last_o           <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/dimmable_seven_segment_scan.sv @@
// Each accepted refresh item runs the button debounce and brightness step, then
// yields DIGITS digit words (default 4), thousands digit first, one word per
// cycle from the back end's digit sequencer when the output is not stalled. A
// two-entry queue sits between the button front end and the sequencer; the first
// word of an item passes through the queue, the sequencer and the output register.
// debounce_ms is written through cfg_we_i/cfg_wdata_i and resets to 50.
// depends on dss_pkg, dss_front, dss_queue, dss_back
module dimmable_seven_segment_scan import dss_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DEB_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 button_low_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic                 show_point_i,
  input  logic                 display_id_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 target_display_o,
  output logic [IDX_OUT_W-1:0] digit_index_o,
  output logic [SEG_W-1:0]     segments_o,
  output logic [LEVEL_W-1:0]   segment_level_o,
  output logic [LEVEL_W-1:0]   point_level_o,
  output logic                 last_o
);

  dss_entry_t entry, head;
  logic       accept, full, empty, pop;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dss_front #(.DIGITS(DIGITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .button_low_i (button_low_i),
    .now_ms_i     (now_ms_i),
    .value_i      (value_i),
    .show_point_i (show_point_i),
    .display_id_i (display_id_i),
    .entry_o      (entry)
  );

  dss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  dss_back #(.DIGITS(DIGITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_display_o (target_display_o),
    .digit_index_o    (digit_index_o),
    .segments_o       (segments_o),
    .segment_level_o  (segment_level_o),
    .point_level_o    (point_level_o),
    .last_o           (last_o)
  );

endmodule

@@ sv/dss_checker.sv @@
// port-level checks for the seven-segment scan, bound to the top level
// depends on dss_pkg and dimmable_seven_segment_scan
module dss_checker import dss_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 target_display_o,
  input logic [IDX_OUT_W-1:0] digit_index_o,
  input logic [LEVEL_W-1:0]   segment_level_o,
  input logic [LEVEL_W-1:0]   point_level_o,
  input logic                 last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_index_o)
      && $stable(segment_level_o))
    else $error("stalled output word changed");

  // digits of one pass come out back to back with the same display and level
  a_next_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o
      && digit_index_o == IDX_OUT_W'($past(digit_index_o) + 2'd1)
      && target_display_o == $past(target_display_o)
      && segment_level_o == $past(segment_level_o))
    else $error("digit sequence broken within a pass");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_level_o == LEVEL_LOW || segment_level_o == LEVEL_MID
      || segment_level_o == LEVEL_HIGH)
    else $error("bad brightness level");

  a_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_level_o != '0 |-> digit_index_o == 2'd2
      && point_level_o == segment_level_o)
    else $error("point lit on wrong digit or level");

endmodule

bind dimmable_seven_segment_scan dss_checker u_dss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .target_display_o (target_display_o),
  .digit_index_o    (digit_index_o),
  .segment_level_o  (segment_level_o),
  .point_level_o    (point_level_o),
  .last_o           (last_o)
);
